// File: src/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants of the quadratic root solver
// Item formats, queue entry, job kind codes and the root clamp helper.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COEF_W        = 32;
  localparam int PROD_W        = 2 * COEF_W;     // |x|*|y|
  localparam int DISC_W        = PROD_W + 2;     // b*b + 4|ac|
  localparam int ROOT_W        = DISC_W / 2;     // isqrt of the discriminant
  localparam int NUM_W         = ROOT_W + 1;     // |-b -/+ dq|
  localparam int DEN_W         = COEF_W + 1;     // |2a|
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_ROOTS  = 2'd0,
    KIND_ZERO_A = 2'd1,
    KIND_NEG_D  = 2'd2
  } kind_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
  } in_item_t;

  typedef struct packed {
    logic                     has_roots;
    logic                     zero_leading;
    logic                     saturated;
    logic signed [COEF_W-1:0] lower_root;
    logic signed [COEF_W-1:0] upper_root;
  } out_item_t;

  // what the back end needs of a coefficient set
  typedef struct packed {
    kind_e                    kind;
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
  } meta_t;

  typedef struct packed {
    meta_t             meta;
    logic [DISC_W-1:0] disc;
  } job_t;

  typedef struct packed {
    logic                     sat;
    logic signed [COEF_W-1:0] val;
  } clamp_t;

  // sign-magnitude quotient to a clamped signed root
  function automatic clamp_t clamp_root(logic [COEF_W-1:0] quo, logic big, logic neg);
    clamp_t r;
    r.sat = 1'b0;
    r.val = COEF_W'(0);
    if (!neg) begin
      if (big || quo[COEF_W-1]) begin
        r.sat = 1'b1;
        r.val = {1'b0, {(COEF_W-1){1'b1}}};
      end else begin
        r.val = quo;
      end
    end else begin
      if (big || (quo > {1'b1, {(COEF_W-1){1'b0}}})) begin
        r.sat = 1'b1;
        r.val = {1'b1, {(COEF_W-1){1'b0}}};
      end else begin
        r.val = COEF_W'(0) - quo;
      end
    end
    return r;
  endfunction

endpackage

// File: src/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver: real roots of a*x^2 + b*x + c
// Fixed-point solver, one coefficient set per item, one result per item.
// ----------------------------------------------------------------------------
// Takes one item per clock and gives one result per clock when the output is
// not stalled. An item passes the intake register (squares and a*c product),
// the job queue, 33 square-root stages (one root bit per stage over the
// 66-bit discriminant), the numerator prep register, 33 divider stages (an
// overflow check stage, then one quotient bit per stage) and the output
// register. The pipeline depth is set by the root width and the 32 quotient
// bits. The intake side stalls only when the 4-entry queue is full; the root
// pipeline advances whenever the output register is free.
// Zero a gives zero_leading with zero roots, a negative discriminant gives
// has_roots low with zero roots, and roots outside the 32-bit range are
// clamped and flagged as saturated.
module quadratic_root_solver #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  qrs_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output qrs_pkg::out_item_t out_item_o
);

  logic          push, pop, empty, full;
  qrs_pkg::job_t push_job, head;

  // intake: products and discriminant classification
  qrs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .push_job_o (push_job),
    .full_i     (full)
  );

  // decoupling queue
  qrs_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty),
    .full_o     (full)
  );

  // sqrt, divide, clamp, order
  qrs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: src/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front: intake and classification
// Registers |b|^2 and |a*c|, then forms the discriminant and the job kind.
// ----------------------------------------------------------------------------
module qrs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  qrs_pkg::in_item_t  in_item_i,
  output logic               push_o,
  output qrs_pkg::job_t      push_job_o,
  input  logic               full_i
);

  localparam int CW = qrs_pkg::COEF_W;
  localparam int PW = qrs_pkg::PROD_W;
  localparam int DW = qrs_pkg::DISC_W;

  logic                 s_vld_q, s_vld_d;
  logic signed [CW-1:0] s_a_q, s_b_q;
  logic [PW-1:0]        s_bb_q, s_ac_q;
  logic                 s_acneg_q, s_azero_q;
  logic                 take;
  logic [CW-1:0]        mag_a, mag_b, mag_c;
  logic [DW-1:0]        bb_w, ac4_w;

  assign in_stall_o = s_vld_q && full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign push_o     = s_vld_q && !full_i;

  assign mag_a = in_item_i.coef_a[CW-1] ? CW'(0) - in_item_i.coef_a : in_item_i.coef_a;
  assign mag_b = in_item_i.coef_b[CW-1] ? CW'(0) - in_item_i.coef_b : in_item_i.coef_b;
  assign mag_c = in_item_i.coef_c[CW-1] ? CW'(0) - in_item_i.coef_c : in_item_i.coef_c;

  always_comb begin
    s_vld_d = s_vld_q;
    if (take) begin
      s_vld_d = 1'b1;
    end else if (push_o) begin
      s_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
    end else begin
      s_vld_q <= s_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s_a_q     <= in_item_i.coef_a;
      s_b_q     <= in_item_i.coef_b;
      s_bb_q    <= PW'(mag_b) * PW'(mag_b);
      s_ac_q    <= PW'(mag_a) * PW'(mag_c);
      s_acneg_q <= in_item_i.coef_a[CW-1] ^ in_item_i.coef_c[CW-1];
      s_azero_q <= (in_item_i.coef_a == CW'(0));
    end
  end

  assign bb_w  = DW'(s_bb_q);
  assign ac4_w = {s_ac_q, 2'b00};

  always_comb begin
    push_job_o.meta.a    = s_a_q;
    push_job_o.meta.b    = s_b_q;
    push_job_o.meta.kind = qrs_pkg::KIND_ROOTS;
    push_job_o.disc      = bb_w - ac4_w;
    if (s_azero_q) begin
      push_job_o.meta.kind = qrs_pkg::KIND_ZERO_A;
    end else if (s_acneg_q && (s_ac_q != PW'(0))) begin
      push_job_o.disc = bb_w + ac4_w;
    end else if (ac4_w > bb_w) begin
      push_job_o.meta.kind = qrs_pkg::KIND_NEG_D;
    end
  end

endmodule

// File: src/qrs_fifo.sv
// ----------------------------------------------------------------------------
// qrs_fifo: job queue
// Short queue that decouples intake from the root pipeline.
// ----------------------------------------------------------------------------
module qrs_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  qrs_pkg::job_t push_job_i,
  input  logic          pop_i,
  output qrs_pkg::job_t head_o,
  output logic          empty_o,
  output logic          full_o
);

  localparam int PTRW = qrs_pkg::QPTR_W;
  localparam int CNTW = qrs_pkg::QCNT_W;

  qrs_pkg::job_t   mem_q [qrs_pkg::QDEPTH];
  logic [PTRW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNTW-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == CNTW'(0));
  assign full_o  = (cnt_q == CNTW'(qrs_pkg::QDEPTH));
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + PTRW'(1) : wr_q;
    rd_d  = pop_i ? rd_q + PTRW'(1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> cnt_q < CNTW'(qrs_pkg::QDEPTH))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != CNTW'(0))
    else $error("queue pop while empty");
`endif

endmodule

// File: src/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div: pipelined restoring divider
// |num| * 2^FRAC_BITS / |den|, one quotient bit per stage, overflow flagged.
// ----------------------------------------------------------------------------
module qrs_div #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [qrs_pkg::NUM_W-1:0]   num_mag_i,
  input  logic                        num_neg_i,
  input  logic [qrs_pkg::DEN_W-1:0]   den_mag_i,
  input  logic                        den_neg_i,
  output logic [qrs_pkg::COEF_W-1:0]  quo_o,
  output logic                        big_o,
  output logic                        neg_o
);

  localparam int QW  = qrs_pkg::COEF_W;
  localparam int NW  = qrs_pkg::NUM_W + FRAC_BITS;
  localparam int LIM = qrs_pkg::DEN_W + QW;
  localparam int RW  = (NW > LIM) ? NW : LIM;

  logic [RW-1:0]              rem_q [QW+1];
  logic [qrs_pkg::DEN_W-1:0]  den_q [QW+1];
  logic [QW-1:0]              quo_q [QW+1];
  logic                       big_q [QW+1];
  logic                       neg_q [QW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RW'(num_mag_i) << FRAC_BITS;
      den_q[0] <= den_mag_i;
      quo_q[0] <= '0;
      big_q[0] <= ((RW'(num_mag_i) << FRAC_BITS) >= (RW'(den_mag_i) << QW));
      neg_q[0] <= num_neg_i ^ den_neg_i;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_bit
    localparam int B = QW - 1 - i;
    logic [RW-1:0] sub;
    assign sub = RW'(den_q[i]) << B;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[i+1] <= den_q[i];
        big_q[i+1] <= big_q[i];
        neg_q[i+1] <= neg_q[i];
        if (rem_q[i] >= sub) begin
          rem_q[i+1] <= rem_q[i] - sub;
          quo_q[i+1] <= quo_q[i] | (QW'(1) << B);
        end else begin
          rem_q[i+1] <= rem_q[i];
          quo_q[i+1] <= quo_q[i];
        end
      end
    end
  end

  assign quo_o = quo_q[QW];
  assign big_o = big_q[QW];
  assign neg_o = neg_q[QW];

endmodule

// File: src/qrs_back.sv
// ----------------------------------------------------------------------------
// qrs_back: root pipeline
// Pipelined square root, numerator prep, two dividers, clamp and ordering.
// ----------------------------------------------------------------------------
module qrs_back #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qrs_pkg::job_t      head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output qrs_pkg::out_item_t out_item_o
);

  localparam int CW = qrs_pkg::COEF_W;
  localparam int DW = qrs_pkg::DISC_W;
  localparam int SN = qrs_pkg::ROOT_W;
  localparam int NM = qrs_pkg::NUM_W;
  localparam int SW = NM + 1;
  localparam int DL = CW + 1;

  logic adv;

  // square root stages
  logic            sq_vld_q  [SN];
  logic [DW-1:0]   sq_rem_q  [SN];
  logic [SN-1:0]   sq_root_q [SN];
  qrs_pkg::meta_t  sq_meta_q [SN];

  // numerator prep
  logic                      p_vld_q;
  qrs_pkg::kind_e            p_kind_q;
  logic [NM-1:0]             p_n1_q, p_n2_q;
  logic                      p_n1neg_q, p_n2neg_q;
  logic [qrs_pkg::DEN_W-1:0] p_den_q;
  logic                      p_denneg_q;

  // divider side band
  logic            dv_vld_q  [DL];
  qrs_pkg::kind_e  dv_kind_q [DL];

  logic [CW-1:0]       q1, q2;
  logic                big1, big2, neg1, neg2;
  qrs_pkg::clamp_t     r1, r2;
  logic                out_vld_q;
  qrs_pkg::out_item_t  out_q, out_d;

  assign adv   = !out_vld_q || !out_stall_i;
  assign pop_o = adv && !empty_i;

  for (genvar j = 0; j < SN; j++) begin : g_sq
    localparam int K = SN - 1 - j;
    logic           v_in;
    logic [DW-1:0]  rem_in;
    logic [SN-1:0]  root_in;
    qrs_pkg::meta_t meta_in;
    logic [DW:0]    trial;
    if (j == 0) begin : g_head
      assign v_in    = !empty_i;
      assign rem_in  = head_i.disc;
      assign root_in = '0;
      assign meta_in = head_i.meta;
    end else begin : g_chain
      assign v_in    = sq_vld_q[j-1];
      assign rem_in  = sq_rem_q[j-1];
      assign root_in = sq_root_q[j-1];
      assign meta_in = sq_meta_q[j-1];
    end
    assign trial = ((DW+1)'(root_in) << (K + 1)) | ((DW+1)'(1) << (2 * K));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[j] <= 1'b0;
      end else if (adv) begin
        sq_vld_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_meta_q[j] <= meta_in;
        if ((DW+1)'(rem_in) >= trial) begin
          sq_rem_q[j]  <= rem_in - DW'(trial);
          sq_root_q[j] <= root_in | (SN'(1) << K);
        end else begin
          sq_rem_q[j]  <= rem_in;
          sq_root_q[j] <= root_in;
        end
      end
    end
  end

  // -b -/+ dq in sign-magnitude, denominator 2a
  logic signed [SW-1:0] nb, dq_s, n1, n2;
  qrs_pkg::meta_t       mt;
  assign mt   = sq_meta_q[SN-1];
  assign nb   = SW'(0) - SW'(mt.b);
  assign dq_s = SW'(sq_root_q[SN-1]);
  assign n1   = nb - dq_s;
  assign n2   = nb + dq_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (adv) begin
      p_vld_q <= sq_vld_q[SN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_kind_q   <= mt.kind;
      p_n1_q     <= n1[SW-1] ? NM'(SW'(0) - n1) : NM'(n1);
      p_n2_q     <= n2[SW-1] ? NM'(SW'(0) - n2) : NM'(n2);
      p_n1neg_q  <= n1[SW-1];
      p_n2neg_q  <= n2[SW-1];
      p_den_q    <= {(mt.a[CW-1] ? CW'(0) - mt.a : mt.a), 1'b0};
      p_denneg_q <= mt.a[CW-1];
    end
  end

  qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
    .clk_i     (clk_i),
    .en_i      (adv),
    .num_mag_i (p_n1_q),
    .num_neg_i (p_n1neg_q),
    .den_mag_i (p_den_q),
    .den_neg_i (p_denneg_q),
    .quo_o     (q1),
    .big_o     (big1),
    .neg_o     (neg1)
  );

  qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
    .clk_i     (clk_i),
    .en_i      (adv),
    .num_mag_i (p_n2_q),
    .num_neg_i (p_n2neg_q),
    .den_mag_i (p_den_q),
    .den_neg_i (p_denneg_q),
    .quo_o     (q2),
    .big_o     (big2),
    .neg_o     (neg2)
  );

  for (genvar k = 0; k < DL; k++) begin : g_band
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else if (adv) begin
        dv_vld_q[k] <= (k == 0) ? p_vld_q : dv_vld_q[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_kind_q[k] <= (k == 0) ? p_kind_q : dv_kind_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign r1 = qrs_pkg::clamp_root(q1, big1, neg1);
  assign r2 = qrs_pkg::clamp_root(q2, big2, neg2);

  always_comb begin
    out_d = '0;
    out_d.zero_leading = (dv_kind_q[DL-1] == qrs_pkg::KIND_ZERO_A);
    if (dv_kind_q[DL-1] == qrs_pkg::KIND_ROOTS) begin
      out_d.has_roots = 1'b1;
      out_d.saturated = r1.sat || r2.sat;
      if (r2.val < r1.val) begin
        out_d.lower_root = r2.val;
        out_d.upper_root = r1.val;
      end else begin
        out_d.lower_root = r1.val;
        out_d.upper_root = r2.val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= dv_vld_q[DL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.has_roots |-> !out_q.zero_leading &&
      (out_q.lower_root <= out_q.upper_root))
    else $error("roots out of order or flags clash");
  a_noroot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.has_roots |-> (out_q.lower_root == CW'(0)) &&
      (out_q.upper_root == CW'(0)) && !out_q.saturated)
    else $error("item without roots carries data");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && dv_vld_q[DL-1] |=> out_vld_q)
    else $error("finished item lost at output");
`endif

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: item-level check of the quadratic root solver
// Directed coefficient table, then random items under random idling on both
// sides; every result is checked field by field against a built-in predictor.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int FRAC  = qrs_pkg::FRAC_BITS_DEF;
  localparam int N_RND = 1530;
  localparam int DRAIN = 200;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  qrs_pkg::in_item_t  in_item_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  qrs_pkg::out_item_t out_item_o;

  qrs_pkg::out_item_t root_q[$];   // predicted results, oldest first
  int        errors = 0;
  bit        stim_done = 1'b0;
  int        hold_off = 0; // long receiver hold, counted by the sink

  always #1 clk_i = ~clk_i;

  quadratic_root_solver dut (.*);

  // floor(sqrt(v)) over the 66-bit discriminant, one bit at a time
  function automatic logic [33:0] isqrt66(logic [65:0] v);
    logic [33:0]  r;
    logic [33:0]  cand;
    logic [67:0]  sq;
    r = '0;
    for (int i = 33; i >= 0; i--) begin
      cand = r | (34'd1 << i);
      sq = 68'(cand) * 68'(cand);
      if (sq <= 68'(v)) r = cand;
    end
    return r;
  endfunction

  // one root: (num << FRAC) / den, truncated toward zero, clamped to 32 bits
  function automatic logic signed [31:0] div_root(logic signed [127:0] num,
                                                  logic signed [127:0] den,
                                                  ref bit sat);
    logic signed [127:0] q;
    q = (num <<< FRAC) / den;
    if (q > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (q < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return q[31:0];
  endfunction

  function automatic qrs_pkg::out_item_t solve_roots(qrs_pkg::in_item_t it);
    qrs_pkg::out_item_t  r;
    logic signed [127:0] a, b, c, d, nb, dq;
    logic signed [31:0]  t0, t1, tmp;
    bit                  sat;
    r = '0;
    sat = 1'b0;
    a = it.coef_a;
    b = it.coef_b;
    c = it.coef_c;
    if (a == 0) begin
      r.zero_leading = 1'b1;
      return r;
    end
    d = b * b - 4 * a * c;
    if (d < 0) return r;      // no real roots
    dq = isqrt66(d[65:0]);
    nb = -b;
    t0 = div_root(nb - dq, 2 * a, sat);
    t1 = div_root(nb + dq, 2 * a, sat);
    if (t1 < t0) begin
      tmp = t0; t0 = t1; t1 = tmp;
    end
    r.has_roots  = 1'b1;
    r.saturated  = sat;
    r.lower_root = t0;
    r.upper_root = t1;
    return r;
  endfunction

  // directed rows; pinned results only where obvious
  typedef struct {
    qrs_pkg::in_item_t  it;
    bit                 pinned;
    qrs_pkg::out_item_t res;
  } dir_row_t;

  dir_row_t dir_tbl[$];

  function automatic dir_row_t row(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                   bit pin = 0, qrs_pkg::out_item_t res = '0);
    dir_row_t r;
    r.it = '{a, b, c};
    r.pinned = pin;
    r.res = res;
    return r;
  endfunction

  initial begin
    // zero leading coefficient
    dir_tbl.push_back(row(0, 32'h7fffffff, 32'h80000000, 1,
                          '{1'b0, 1'b1, 1'b0, 32'd0, 32'd0}));
    dir_tbl.push_back(row(0, 0, 0, 1, '{1'b0, 1'b1, 1'b0, 32'd0, 32'd0}));
    // negative discriminant: x^2 + 1
    dir_tbl.push_back(row(32'h10000, 0, 32'h10000, 1, '{1'b0, 1'b0, 1'b0, 32'd0, 32'd0}));
    dir_tbl.push_back(row(32'h7fffffff, 0, 32'h7fffffff, 1, '0));
    // x^2 - 1: roots -1, 1
    dir_tbl.push_back(row(32'h10000, 0, 32'hffff0000, 1,
                          '{1'b1, 1'b0, 1'b0, 32'hffff0000, 32'h10000}));
    // double root: x^2 - 2x + 1
    dir_tbl.push_back(row(32'h10000, 32'hfffe0000, 32'h10000, 1,
                          '{1'b1, 1'b0, 1'b0, 32'h10000, 32'h10000}));
    // all zero except a: double root at zero
    dir_tbl.push_back(row(32'h10000, 0, 0, 1, '{1'b1, 1'b0, 1'b0, 32'd0, 32'd0}));
    // extremes, saturation
    dir_tbl.push_back(row(1, 32'h7fffffff, 0));
    dir_tbl.push_back(row(1, 32'h80000000, 0));
    dir_tbl.push_back(row(32'hffffffff, 32'h80000000, 32'h7fffffff));
    dir_tbl.push_back(row(32'h80000000, 32'h80000000, 32'h80000000));
    dir_tbl.push_back(row(32'h80000000, 32'h7fffffff, 32'h7fffffff));
    dir_tbl.push_back(row(32'h7fffffff, 32'h7fffffff, 32'h80000000));
    dir_tbl.push_back(row(32'h7fffffff, 32'h80000000, 32'h80000000));
    dir_tbl.push_back(row(1, 0, 32'h80000000));
    dir_tbl.push_back(row(32'hffffffff, 0, 32'h7fffffff));
    dir_tbl.push_back(row(32'hfffe0000, 32'h30000, 32'h50000));
    dir_tbl.push_back(row(32'h8000, 32'hffff8000, 32'hffffc000));
    dir_tbl.push_back(row(32'hffffffff, 32'hffffffff, 32'hffffffff));
    dir_tbl.push_back(row(32'h55555555, 32'haaaaaaaa, 32'h80000001));
  end

  function automatic logic [31:0] rnd_coef();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 8'hff)) - 128) <<< FRAC;
      2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      4: return 32'($signed($urandom_range(0, 40)) - 20);
      default: return 32'($signed($urandom_range(0, 32'h7ffff)) - 32'h40000) <<< 4;
    endcase
  endfunction

  // random coefficient set; mostly solvable equations, some noise
  function automatic qrs_pkg::in_item_t rnd_item();
    qrs_pkg::in_item_t  it;
    logic signed [31:0] r1, r2, k;
    if ($urandom_range(0, 3) == 0) begin
      it = '{rnd_coef(), rnd_coef(), rnd_coef()};
      if ($urandom_range(0, 15) == 0) it.coef_a = '0;
    end else begin
      // build a*(x-r1)(x-r2) from small integer roots and scale
      r1 = $signed($urandom_range(0, 200)) - 100;
      r2 = $signed($urandom_range(0, 200)) - 100;
      k  = $signed($urandom_range(1, 64)) * ($urandom_range(0, 1) ? 1 : -1);
      it.coef_a = k <<< FRAC;
      it.coef_b = (-k * (r1 + r2)) <<< FRAC;
      it.coef_c = (k * r1 * r2) <<< FRAC;
      if ($urandom_range(0, 3) == 0) it.coef_c = it.coef_c + 32'($urandom_range(0, 16'hffff));
      if ($urandom_range(0, 7) == 0) it.coef_b = -it.coef_b;
    end
    return it;
  endfunction

  // offer one item, wait for acceptance; valid stays up across a zero gap
  task automatic send_item(qrs_pkg::in_item_t it);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    root_q.push_back(solve_roots(it));
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // sender
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tbl[i]) begin
      send_item(dir_tbl[i].it);
      if (dir_tbl[i].pinned && root_q[$] !== dir_tbl[i].res) begin
        $error("row %0d: predictor gives %h, table says %h", i, root_q[$], dir_tbl[i].res);
        errors++;
      end
    end
    for (int n = 0; n < N_RND; n++) begin
      // long receiver hold while items keep coming in
      if (n == 300) hold_off = 400;
      // sender pause until the pipe is empty
      if (n == 900) begin
        in_valid_i <= 1'b0;
        wait (root_q.size() == 0);
      end
      send_item(rnd_item());
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: random stall, checks on acceptance
  initial begin
    qrs_pkg::out_item_t exp_r;
    int                 wait_n;
    wait_n = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (root_q.size() == 0) begin
          $error("result with nothing expected: %h", out_item_o);
          errors++;
        end else begin
          exp_r = root_q.pop_front();
          if (out_item_o.has_roots !== exp_r.has_roots) begin
            $error("has_roots exp %0b got %0b", exp_r.has_roots, out_item_o.has_roots);
            errors++;
          end
          if (out_item_o.zero_leading !== exp_r.zero_leading) begin
            $error("zero_leading exp %0b got %0b", exp_r.zero_leading,
                   out_item_o.zero_leading);
            errors++;
          end
          if (out_item_o.saturated !== exp_r.saturated) begin
            $error("saturated exp %0b got %0b", exp_r.saturated, out_item_o.saturated);
            errors++;
          end
          if (out_item_o.lower_root !== exp_r.lower_root) begin
            $error("lower_root exp %h got %h", exp_r.lower_root, out_item_o.lower_root);
            errors++;
          end
          if (out_item_o.upper_root !== exp_r.upper_root) begin
            $error("upper_root exp %h got %h", exp_r.upper_root, out_item_o.upper_root);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        out_stall_i <= 1'b1;
        hold_off--;
      end else if (wait_n > 0) begin
        out_stall_i <= 1'b1;
        wait_n--;
      end else begin
        // new draw when no wait is pending; at least a third of the time no stall
        wait_n = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 16);
        out_stall_i <= (wait_n != 0);
        if (wait_n != 0) wait_n--;
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done && root_q.size() == 0);
    repeat (DRAIN) @(posedge clk_i);
    if (errors == 0 && root_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
